/* hw/rtl/csrmv_pkg.sv */
// shared types and constants for the csr sparse matrix-vector product block
// no dependencies

package csrmv_pkg;

    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int IDX_W            = 10;
    localparam int ROW_W            = 10;
    localparam int DATA_W           = 32;
    localparam int QDEPTH           = 4;
    localparam int QAW              = $clog2(QDEPTH);
    localparam int QCW              = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_END     = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // one word of work handed from front to back
    typedef struct packed {
        logic              is_end;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] vec;
        logic              last;
    } t_work;

    typedef struct packed {
        logic           empty;
        logic [QCW-1:0] count;
    } t_qstat;

endpackage

/* hw/rtl/csrmv_if.sv */
// handshake channels of the csr sparse matrix-vector product block
// depends on csrmv_pkg

interface csrmv_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       command;
    logic [csrmv_pkg::IDX_W-1:0]      index;
    logic signed [csrmv_pkg::DATA_W-1:0] value;
    logic                             final_row;

    modport source (output valid, command, index, value, final_row, input ready);
    modport sink (input valid, command, index, value, final_row, output ready);
endinterface

interface csrmv_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [csrmv_pkg::DATA_W-1:0] row_sum;
    logic [csrmv_pkg::ROW_W-1:0]         row_number;
    logic                                last_of_matrix;

    modport source (output valid, row_sum, row_number, last_of_matrix, input ready);
    modport sink (input valid, row_sum, row_number, last_of_matrix, output ready);
endinterface

/* hw/rtl/csrmv_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies

module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/csrmv_front.sv */
// front end: accepts input words, stores vector elements, looks up the
// vector element of each nonzero and pushes work to the queue
// depends on csrmv_pkg, csrmv_if, csrmv_ram

module csrmv_front #(
    parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
    localparam int AW          = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csrmv_in_if.sink              i_item,
    input  csrmv_pkg::t_qstat     i_qstat,
    output logic                  o_push,
    output csrmv_pkg::t_work      o_work
);

    logic                             accept;
    logic                             in_range;
    logic                             is_load;
    logic                             is_nz;
    logic                             is_end;
    logic [AW-1:0]                    addr;
    logic [csrmv_pkg::DATA_W-1:0]     rdata;
    logic [csrmv_pkg::QCW-1:0]        pending;

    logic                             r_s1_valid;
    logic                             n_s1_valid;
    logic                             r_s1_end;
    logic                             r_s1_hit;
    logic                             r_s1_last;
    logic [csrmv_pkg::DATA_W-1:0]     r_s1_value;

    // credit: queue entries plus the word in the lookup stage
    assign pending      = i_qstat.count + csrmv_pkg::QCW'(r_s1_valid);
    assign i_item.ready = (pending < csrmv_pkg::QCW'(csrmv_pkg::QDEPTH));
    assign accept       = i_item.valid && i_item.ready;

    assign in_range = (32'(i_item.index) < 32'(VECTOR_DEPTH));
    assign addr     = AW'(i_item.index);

    always_comb begin
        is_load = 1'b0;
        is_nz   = 1'b0;
        is_end  = 1'b0;
        unique case (csrmv_pkg::t_cmd'(i_item.command))
            csrmv_pkg::CMD_LOAD:    is_load = 1'b1;
            csrmv_pkg::CMD_NONZERO: is_nz   = 1'b1;
            csrmv_pkg::CMD_END:     is_end  = 1'b1;
            default: ;
        endcase
    end

    csrmv_ram #(
        .WIDTH (csrmv_pkg::DATA_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (accept && is_load && in_range),
        .i_waddr (addr),
        .i_wdata ($unsigned(i_item.value)),
        .i_re    (accept && is_nz && in_range),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    assign n_s1_valid = accept && (is_nz || is_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_end   <= is_end;
            r_s1_hit   <= is_nz && in_range;
            r_s1_last  <= i_item.final_row;
            r_s1_value <= $unsigned(i_item.value);
        end
    end

    // out-of-range nonzero contributes a zero product
    always_comb begin
        o_push        = r_s1_valid;
        o_work.is_end = r_s1_end;
        o_work.value  = r_s1_value;
        o_work.vec    = r_s1_hit ? rdata : '0;
        o_work.last   = r_s1_last;
    end

    a_lookup_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(accept))
        else $error("lookup stage loaded without an accepted word");

endmodule

/* hw/rtl/csrmv_fifo.sv */
// short work queue between the front end and the multiply-accumulate back end
// depends on csrmv_pkg

module csrmv_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csrmv_pkg::t_work  i_work,
    input  logic              i_pop,
    output csrmv_pkg::t_work  o_head,
    output csrmv_pkg::t_qstat o_qstat
);

    csrmv_pkg::t_work                r_mem [csrmv_pkg::QDEPTH];
    logic [csrmv_pkg::QAW-1:0]       r_wptr;
    logic [csrmv_pkg::QAW-1:0]       n_wptr;
    logic [csrmv_pkg::QAW-1:0]       r_rptr;
    logic [csrmv_pkg::QAW-1:0]       n_rptr;
    logic [csrmv_pkg::QCW-1:0]       r_count;
    logic [csrmv_pkg::QCW-1:0]       n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == csrmv_pkg::QAW'(csrmv_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == csrmv_pkg::QAW'(csrmv_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    assign o_head        = r_mem[r_rptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == csrmv_pkg::QCW'(csrmv_pkg::QDEPTH)) |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("pop from empty queue");

endmodule

/* hw/rtl/csrmv_back.sv */
// back end: multiply stage, row accumulator, row counter and result register
// depends on csrmv_pkg, csrmv_if

module csrmv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csrmv_pkg::t_work  i_head,
    input  csrmv_pkg::t_qstat i_qstat,
    output logic              o_pop,
    csrmv_out_if.source       o_result
);

    logic                             out_free;
    logic                             adv;
    logic                             retire;
    logic                             emit;
    logic [csrmv_pkg::DATA_W-1:0]     mul;

    logic                             r_p_valid;
    logic                             n_p_valid;
    logic                             r_p_end;
    logic                             r_p_last;
    logic [csrmv_pkg::DATA_W-1:0]     r_p_prod;

    logic [csrmv_pkg::DATA_W-1:0]     r_sum;
    logic [csrmv_pkg::DATA_W-1:0]     n_sum;
    logic [csrmv_pkg::ROW_W-1:0]      r_row;
    logic [csrmv_pkg::ROW_W-1:0]      n_row;

    logic                             r_o_valid;
    logic                             n_o_valid;
    logic [csrmv_pkg::DATA_W-1:0]     r_o_sum;
    logic [csrmv_pkg::ROW_W-1:0]      r_o_row;
    logic                             r_o_last;

    assign out_free = !r_o_valid || o_result.ready;
    // only an end-of-row word waits on the result register
    assign adv      = !(r_p_valid && r_p_end) || out_free;
    assign o_pop    = adv && !i_qstat.empty;
    assign retire   = adv && r_p_valid;
    assign emit     = retire && r_p_end;
    assign mul      = i_head.value * i_head.vec;

    always_comb begin
        n_p_valid = adv ? o_pop : r_p_valid;
        n_sum     = r_sum;
        n_row     = r_row;
        if (retire) begin
            n_sum = r_p_end ? '0 : r_sum + r_p_prod;
        end
        if (emit) begin
            n_row = r_p_last ? '0 : r_row + 1'b1;
        end
        n_o_valid = emit || (r_o_valid && !o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_sum     <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
            r_sum     <= n_sum;
            r_row     <= n_row;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_end  <= i_head.is_end;
            r_p_last <= i_head.last;
            r_p_prod <= mul;
        end
        if (emit) begin
            r_o_sum  <= r_sum;
            r_o_row  <= r_row;
            r_o_last <= r_p_last;
        end
    end

    assign o_result.valid          = r_o_valid;
    assign o_result.row_sum        = $signed(r_o_sum);
    assign o_result.row_number     = r_o_row;
    assign o_result.last_of_matrix = r_o_last;

    a_sum_cleared_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_sum == '0))
        else $error("row sum not cleared after end of row");

endmodule

/* hw/rtl/csr_sparse_matrix_vector_product.sv */
// top level of the csr sparse matrix-vector product block
// depends on csrmv_pkg, csrmv_if, csrmv_front, csrmv_fifo, csrmv_back

// Streams a dense vector into an on-chip vector RAM (command load), then
// accumulates matrix nonzeros against it (command nonzero) and emits one
// wrapping 32-bit row sum per end-of-row word, with the row number, which
// returns to zero after an end-of-row word marked final row. The block
// takes one input word per clock when the result side keeps up; an accepted
// end-of-row word passes the registered vector RAM read, the four-word work
// queue and the multiplier register before its row result is loaded into
// the output register, straight from the accumulator. A stalled result
// holds the back end only once an end-of-row word reaches the multiplier
// stage; nonzeros ahead of it keep draining, and the input stalls when the
// queue fills. Vector elements that were never loaded read as unknown data.

module csr_sparse_matrix_vector_product #(
    parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csrmv_in_if.sink      i_item,
    csrmv_out_if.source   o_result
);

    logic               push;
    logic               pop;
    csrmv_pkg::t_work   work;
    csrmv_pkg::t_work   head;
    csrmv_pkg::t_qstat  qstat;

    csrmv_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_qstat (qstat),
        .o_push  (push),
        .o_work  (work)
    );

    csrmv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    csrmv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench of csr_sparse_matrix_vector_product: loads dense vectors, streams csr rows
// and checks every row result against a behavioral copy kept here
// depends on csrmv_pkg, csrmv_if and the block itself

module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [csrmv_pkg::DATA_W-1:0] sum;
        logic [csrmv_pkg::ROW_W-1:0]  row;
        logic                         last;
    } t_row_result;

    logic i_clk;
    logic i_rst_n;

    csrmv_in_if  item_ch ();
    csrmv_out_if result_ch ();

    csr_sparse_matrix_vector_product DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    logic [csrmv_pkg::DATA_W-1:0] vec_copy [csrmv_pkg::VECTOR_DEPTH_DEF];
    bit                           col_loaded [csrmv_pkg::VECTOR_DEPTH_DEF];
    int                           loaded_cols [$];
    logic [csrmv_pkg::DATA_W-1:0] row_acc = '0;
    logic [csrmv_pkg::ROW_W-1:0]  row_idx = '0;
    t_row_result                  rows_due [$];
    t_row_result                  got_row;
    t_row_result                  want_row;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;
    bit hold_ack       = 1'b0;
    int cycle_cnt      = 0;
    int n_errors       = 0;
    int words_sent     = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        result_ch.ready <= i_rst_n && (hold_left == 0) &&
                           ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic void apply_word(csrmv_pkg::t_cmd cmd,
                                       logic [csrmv_pkg::IDX_W-1:0] idx,
                                       logic [csrmv_pkg::DATA_W-1:0] val, logic fin);
        logic [csrmv_pkg::DATA_W-1:0] prod;
        case (cmd)
            csrmv_pkg::CMD_LOAD: begin
                vec_copy[idx] = val;
                if (!col_loaded[idx]) begin
                    col_loaded[idx] = 1'b1;
                    loaded_cols.push_back(int'(idx));
                end
            end
            csrmv_pkg::CMD_NONZERO: begin
                prod    = val * vec_copy[idx];
                row_acc = row_acc + prod;
            end
            csrmv_pkg::CMD_END: begin
                rows_due.push_back(t_row_result'{row_acc, row_idx, fin});
                row_acc = '0;
                row_idx = fin ? '0 : row_idx + 1'b1;
            end
            default: ;
        endcase
    endfunction

    // results are sampled mid-cycle, the handshake completes at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got_row = t_row_result'{result_ch.row_sum, result_ch.row_number,
                                    result_ch.last_of_matrix};
            if (rows_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected row result: sum %h row %0d last %b",
                             got_row.sum, got_row.row, got_row.last);
            end else begin
                want_row = rows_due.pop_front();
                if (got_row != want_row) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"row mismatch: expected sum %h row %0d last %b, ",
                                  "got sum %h row %0d last %b"},
                                 want_row.sum, want_row.row, want_row.last,
                                 got_row.sum, got_row.row, got_row.last);
                end
            end
        end
    end

    task automatic send_word(csrmv_pkg::t_cmd cmd, logic [csrmv_pkg::IDX_W-1:0] idx,
                             logic [csrmv_pkg::DATA_W-1:0] val, logic fin);
        bit took;
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.command   <= cmd;
        item_ch.index     <= idx;
        item_ch.value     <= val;
        item_ch.final_row <= fin;
        do begin
            @(negedge i_clk);
            took = item_ch.ready;
            @(posedge i_clk);
        end while (!took);
        apply_word(cmd, idx, val, fin);
        words_sent++;
    endtask

    task automatic wait_rows_out();
        item_ch.valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [csrmv_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [csrmv_pkg::IDX_W-1:0] pick_index();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return csrmv_pkg::IDX_W'($urandom_range(csrmv_pkg::VECTOR_DEPTH_DEF - 1));
        endcase
    endfunction

    function automatic logic [csrmv_pkg::IDX_W-1:0] pick_loaded();
        return csrmv_pkg::IDX_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
    endfunction

    task automatic send_row(int n_nonzeros, logic fin);
        repeat (n_nonzeros)
            send_word(csrmv_pkg::CMD_NONZERO, pick_loaded(), pick_value(),
                      1'($urandom_range(1)));
        send_word(csrmv_pkg::CMD_END, csrmv_pkg::IDX_W'($urandom), $urandom, fin);
    endtask

    // mostly well-formed csr rows over loaded columns, with some noise
    task automatic stream_csr(int n_words);
        int pick;
        int target;
        target = words_sent + n_words;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 8))
                    send_word(csrmv_pkg::CMD_LOAD, pick_index(), pick_value(),
                              1'($urandom_range(1)));
            end else if (pick < 85) begin
                send_row($urandom_range(0, 8), $urandom_range(7) == 0);
            end else if (pick < 92) begin
                send_word(csrmv_pkg::CMD_NONE, csrmv_pkg::IDX_W'($urandom), $urandom,
                          1'($urandom_range(1)));
            end else if (pick < 97) begin
                send_word(csrmv_pkg::CMD_NONZERO, pick_loaded(), pick_value(), 1'b1);
                send_word(csrmv_pkg::CMD_LOAD, pick_index(), pick_value(), 1'b0);
            end else begin
                send_word(csrmv_pkg::CMD_END, csrmv_pkg::IDX_W'($urandom), $urandom, 1'b1);
            end
        end
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(csrmv_pkg::CMD_LOAD, 10'd0, 32'h7fff_ffff, 1'b0);
        send_word(csrmv_pkg::CMD_LOAD, 10'd1023, 32'h8000_0000, 1'b0);
        send_word(csrmv_pkg::CMD_LOAD, 10'd512, 32'hffff_ffff, 1'b0);
        send_word(csrmv_pkg::CMD_LOAD, 10'd1, 32'd3, 1'b1);
        // wrapping products and sums
        send_word(csrmv_pkg::CMD_NONZERO, 10'd0, 32'd2, 1'b0);
        send_word(csrmv_pkg::CMD_NONZERO, 10'd1023, 32'hffff_ffff, 1'b0);
        send_word(csrmv_pkg::CMD_NONZERO, 10'd512, 32'h8000_0000, 1'b0);
        send_word(csrmv_pkg::CMD_NONZERO, 10'd0, 32'h7fff_ffff, 1'b1);
        send_word(csrmv_pkg::CMD_END, 10'd0, 32'd0, 1'b0);
        // empty row
        send_word(csrmv_pkg::CMD_END, 10'd1023, 32'hffff_ffff, 1'b0);
        send_word(csrmv_pkg::CMD_NONE, 10'd1023, 32'hffff_ffff, 1'b1);
        send_word(csrmv_pkg::CMD_NONZERO, 10'd1, 32'd7, 1'b1);
        send_word(csrmv_pkg::CMD_NONE, 10'd1, 32'd5, 1'b0);
        send_word(csrmv_pkg::CMD_NONZERO, 10'd1, 32'd0, 1'b0);
        send_word(csrmv_pkg::CMD_END, 10'd1023, 32'hffff_ffff, 1'b1);
        send_word(csrmv_pkg::CMD_END, 10'd0, 32'd0, 1'b1);
        // load then read the same element back to back
        send_word(csrmv_pkg::CMD_LOAD, 10'd5, 32'd11, 1'b0);
        send_word(csrmv_pkg::CMD_NONZERO, 10'd5, 32'd3, 1'b0);
        send_word(csrmv_pkg::CMD_LOAD, 10'd5, 32'd13, 1'b0);
        send_word(csrmv_pkg::CMD_NONZERO, 10'd5, 32'd1, 1'b0);
        send_word(csrmv_pkg::CMD_END, 10'd5, 32'd0, 1'b0);
        wait_rows_out();
    endtask

    // row number counts up across a run of empty rows
    task automatic test_row_count();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(csrmv_pkg::CMD_END, 10'd0, 32'd0, 1'b1);
        repeat (30)
            send_word(csrmv_pkg::CMD_END, csrmv_pkg::IDX_W'($urandom), $urandom, 1'b0);
        send_row(3, 1'b1);
        wait_rows_out();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int n_words);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        stream_csr(n_words);
        wait_rows_out();
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req      <= ~hold_req;
        stream_csr(80);
        wait_rows_out();
        repeat ($urandom_range(5, 30)) @(posedge i_clk);
        stream_csr(30);
        wait_rows_out();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.command   = csrmv_pkg::CMD_NONE;
        item_ch.index     = '0;
        item_ch.value     = '0;
        item_ch.final_row = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0, 120);
        test_random_phase(87, 0, 110);
        test_random_phase(0, 87, 110);
        test_random_phase(10, 10, 110);
        test_backpressure();
        test_row_count();

        wait_rows_out();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
